@@ src/pas_pkg.sv @@
// Shared types and constants for the pedestal average and subtract engine.
// No dependencies; used by pas_store, pas_div and the top level.
`default_nettype none

package pas_pkg;

  // Field widths of one input item and one result item
  localparam int OPCODE_W  = 2;
  localparam int WINDOW_W  = 6;
  localparam int CHANNEL_W = 4;
  localparam int SIDX_W    = 5;
  localparam int SAMPLE_W  = 12;
  localparam int CORR_W    = 24;
  localparam int ROUND_W   = 10;
  localparam int ROUNDS_W  = 11;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Pedestal store word and its saturation value
  localparam int DATA_W = 23;
  localparam logic [DATA_W-1:0] STORE_MAX = '1;

  // Rounds register: reset value and clamp
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 11'd1;
  localparam logic [ROUNDS_W-1:0] ROUNDS_MAX   = 11'd1024;

  // Default geometry of the store
  localparam int WINDOWS_DEF  = 64;
  localparam int CHANNELS_DEF = 16;
  localparam int SAMPLES_DEF  = 32;

  // Opcodes
  typedef logic [OPCODE_W-1:0] opcode_t;
  localparam opcode_t OP_CLEAR = 2'd0;
  localparam opcode_t OP_ACCUM = 2'd1;
  localparam opcode_t OP_SUB   = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EXEC,
    ST_ROUND,
    ST_AV_RD,
    ST_AV_START,
    ST_AV_WAIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ src/pas_store.sv @@
// Pedestal store: single write port, single registered read port.
// Depends on pas_pkg for the word width.
`default_nettype none

module pas_store #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [pas_pkg::DATA_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [pas_pkg::DATA_W-1:0] rd_data
);

  logic [pas_pkg::DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/pas_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pas_pkg for dividend and divisor widths.
`default_nettype none

module pas_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [pas_pkg::DATA_W-1:0]   dividend,
  input  wire logic [pas_pkg::ROUNDS_W-1:0] divisor,
  output logic                              done,
  output logic      [pas_pkg::DATA_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(pas_pkg::DATA_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pas_pkg::DATA_W - 1);

  logic                           busy;
  logic [CNT_W-1:0]               cnt;
  logic [pas_pkg::ROUNDS_W-1:0]   dvs;
  logic [pas_pkg::ROUNDS_W-1:0]   rem;
  logic [pas_pkg::ROUNDS_W:0]     trial;
  logic [pas_pkg::ROUNDS_W:0]     diff;
  logic                           q_bit;

  // Shift the next dividend bit into the partial remainder and try the subtract
  always_comb begin
    trial = {rem, quotient[pas_pkg::DATA_W-1]};
    diff  = trial - {1'b0, dvs};
    q_bit = (trial >= {1'b0, dvs});
  end

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Datapath: dividend shifts out as the quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[pas_pkg::DATA_W-2:0], q_bit};
      rem      <= q_bit ? diff[pas_pkg::ROUNDS_W-1:0] : trial[pas_pkg::ROUNDS_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ src/pedestal_average_and_subtract_top.sv @@
// Pedestal average and subtract engine. One item is taken at a time; s_axis_tready is high
// only while the sequencer is idle, and a finished result waits in the output register
// while the next item is taken. After reset the store is zeroed by a clearing pass over
// all WINDOWS*CHANNELS*SAMPLES slots (32768 by default) during which no item is accepted.
// Subtract and accumulate on a slot in range read it through the store's registered read
// port, and accumulate writes the sum back; a slot out of range skips the store, opcode
// three goes straight to its result, and a result held back by the output adds its wait.
// The clear opcode repeats the clearing pass.
// An accumulate that completes an averaging also walks its window of CHANNELS*SAMPLES
// slots; each slot is read, divided by the bit-serial divider, then written back.
// Depends on pas_pkg, pas_store and pas_div.
`default_nettype none

module pedestal_average_and_subtract_top #(
  parameter int WINDOWS  = pas_pkg::WINDOWS_DEF,
  parameter int CHANNELS = pas_pkg::CHANNELS_DEF,
  parameter int SAMPLES  = pas_pkg::SAMPLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Rounds register write
  input  wire logic                               cfg_we,
  input  wire logic [pas_pkg::ROUNDS_W-1:0]       cfg_wdata,
  // Input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // opcode[1:0], window[7:2], channel[11:8], sample_index[16:12], sample[28:17], zero[31:29]
  input  wire logic [pas_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tlast,
  // Result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // corrected[23:0], averaged[24], round_now[34:25], zero[39:35]
  output logic      [pas_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int DEPTH  = WINDOWS * CHANNELS * SAMPLES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WSPAN  = CHANNELS * SAMPLES;
  localparam int K_W    = (WSPAN > 1) ? $clog2(WSPAN) : 1;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [K_W-1:0]    K_LAST    = K_W'(WSPAN - 1);
  localparam int PAD_W = pas_pkg::OUT_TDATA_W - pas_pkg::CORR_W - 1 - pas_pkg::ROUND_W;

  // Input field positions
  localparam int WIN_LO = pas_pkg::OPCODE_W;
  localparam int CH_LO  = WIN_LO + pas_pkg::WINDOW_W;
  localparam int SI_LO  = CH_LO + pas_pkg::CHANNEL_W;
  localparam int SMP_LO = SI_LO + pas_pkg::SIDX_W;

  pas_pkg::state_t state, state_next;

  // Configuration and round counter
  logic [pas_pkg::ROUNDS_W-1:0] rounds;
  logic [pas_pkg::ROUNDS_W-1:0] eff_rounds;
  logic [pas_pkg::ROUND_W-1:0]  round_cnt;
  logic [pas_pkg::ROUNDS_W-1:0] round_next;

  // Registered item
  pas_pkg::opcode_t              item_op;
  logic [pas_pkg::WINDOW_W-1:0]  item_window;
  logic [pas_pkg::CHANNEL_W-1:0] item_channel;
  logic [pas_pkg::SIDX_W-1:0]    item_sidx;
  logic [pas_pkg::SAMPLE_W-1:0]  item_sample;
  logic                          item_last;
  logic                          item_pending;

  // Result being built
  logic [pas_pkg::CORR_W-1:0]    corr_r;
  logic                          avg_r;

  // Output register
  logic                          out_valid;
  logic [pas_pkg::CORR_W-1:0]    out_corrected;
  logic                          out_averaged;
  logic [pas_pkg::ROUND_W-1:0]   out_round;
  logic                          load_out;

  // Sweep counters
  logic [ADDR_W-1:0]             clr_addr;
  logic [K_W-1:0]                k;

  // Decode of the incoming transfer
  pas_pkg::opcode_t              in_op;
  logic [pas_pkg::WINDOW_W-1:0]  in_window;
  logic [pas_pkg::CHANNEL_W-1:0] in_channel;
  logic [pas_pkg::SIDX_W-1:0]    in_sidx;
  logic                          in_slot_ok;
  logic                          item_slot_ok;
  logic                          item_win_ok;

  // Addresses
  logic [31:0]                   slot_full;
  logic [31:0]                   av_full;
  logic [ADDR_W-1:0]             slot_addr;
  logic [ADDR_W-1:0]             av_addr;

  // Store and divider connections
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [pas_pkg::DATA_W-1:0]    wr_data;
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  logic [pas_pkg::DATA_W-1:0]    rd_data;
  logic                          div_start;
  logic                          div_done;
  logic [pas_pkg::DATA_W-1:0]    quotient;

  // Accumulate and subtract arithmetic
  logic [pas_pkg::DATA_W:0]      acc_sum;
  logic [pas_pkg::DATA_W-1:0]    ped;

  pas_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (eff_rounds),
    .done     (div_done),
    .quotient (quotient)
  );

  // Unpack the incoming transfer
  assign in_op      = s_axis_tdata[pas_pkg::OPCODE_W-1:0];
  assign in_window  = s_axis_tdata[WIN_LO +: pas_pkg::WINDOW_W];
  assign in_channel = s_axis_tdata[CH_LO +: pas_pkg::CHANNEL_W];
  assign in_sidx    = s_axis_tdata[SI_LO +: pas_pkg::SIDX_W];

  // Slot range checks
  assign in_slot_ok   = (32'(in_window) < 32'(WINDOWS)) && (32'(in_channel) < 32'(CHANNELS))
                        && (32'(in_sidx) < 32'(SAMPLES));
  assign item_win_ok  = (32'(item_window) < 32'(WINDOWS));
  assign item_slot_ok = item_win_ok && (32'(item_channel) < 32'(CHANNELS))
                        && (32'(item_sidx) < 32'(SAMPLES));

  // Slot address and window walk address
  assign slot_full = (32'(item_window) * 32'(CHANNELS) + 32'(item_channel)) * 32'(SAMPLES)
                     + 32'(item_sidx);
  assign av_full   = 32'(item_window) * 32'(WSPAN) + 32'(k);
  assign slot_addr = slot_full[ADDR_W-1:0];
  assign av_addr   = av_full[ADDR_W-1:0];

  // Clamp rounds to 1..1024
  always_comb begin
    if (rounds == '0) begin
      eff_rounds = pas_pkg::ROUNDS_RESET;
    end else if (rounds > pas_pkg::ROUNDS_MAX) begin
      eff_rounds = pas_pkg::ROUNDS_MAX;
    end else begin
      eff_rounds = rounds;
    end
  end

  assign round_next = {1'b0, round_cnt} + 1'b1;

  // Saturating accumulate and pedestal pick
  assign acc_sum = {1'b0, rd_data} + (pas_pkg::DATA_W + 1)'(item_sample);
  assign ped     = item_slot_ok ? rd_data : '0;

  assign load_out = (state == pas_pkg::ST_DONE) && (!out_valid || m_axis_tready);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pas_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store / divider control
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = slot_addr;
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = slot_addr;
    div_start  = 1'b0;
    case (state)
      pas_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (clr_addr == ADDR_LAST) begin
          state_next = item_pending ? pas_pkg::ST_DONE : pas_pkg::ST_IDLE;
        end
      end
      pas_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_op)
            pas_pkg::OP_CLEAR: state_next = pas_pkg::ST_CLEAR;
            pas_pkg::OP_ACCUM: state_next = in_slot_ok ? pas_pkg::ST_RD : pas_pkg::ST_ROUND;
            pas_pkg::OP_SUB:   state_next = in_slot_ok ? pas_pkg::ST_RD : pas_pkg::ST_EXEC;
            default:           state_next = pas_pkg::ST_DONE;
          endcase
        end
      end
      pas_pkg::ST_RD: begin
        rd_en      = 1'b1;
        state_next = pas_pkg::ST_EXEC;
      end
      pas_pkg::ST_EXEC: begin
        if (item_op == pas_pkg::OP_ACCUM) begin
          wr_en      = 1'b1;
          wr_data    = acc_sum[pas_pkg::DATA_W] ? pas_pkg::STORE_MAX
                                                : acc_sum[pas_pkg::DATA_W-1:0];
          state_next = pas_pkg::ST_ROUND;
        end else begin
          state_next = pas_pkg::ST_DONE;
        end
      end
      pas_pkg::ST_ROUND: begin
        if (item_last && (round_next >= eff_rounds) && item_win_ok) begin
          state_next = pas_pkg::ST_AV_RD;
        end else begin
          state_next = pas_pkg::ST_DONE;
        end
      end
      pas_pkg::ST_AV_RD: begin
        rd_en      = 1'b1;
        rd_addr    = av_addr;
        state_next = pas_pkg::ST_AV_START;
      end
      pas_pkg::ST_AV_START: begin
        div_start  = 1'b1;
        state_next = pas_pkg::ST_AV_WAIT;
      end
      pas_pkg::ST_AV_WAIT: begin
        if (div_done) begin
          wr_en      = 1'b1;
          wr_addr    = av_addr;
          wr_data    = quotient;
          state_next = (k == K_LAST) ? pas_pkg::ST_DONE : pas_pkg::ST_AV_RD;
        end
      end
      pas_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = pas_pkg::ST_IDLE;
        end
      end
      default: state_next = pas_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == pas_pkg::ST_IDLE);

  // Control registers: rounds, round counter, sweep counter, pending flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rounds       <= pas_pkg::ROUNDS_RESET;
      round_cnt    <= '0;
      clr_addr     <= '0;
      item_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        rounds <= cfg_wdata;
      end
      // Advance the counter at the end of a capture; wrap when rounds are reached
      if (state == pas_pkg::ST_ROUND && item_last) begin
        if (round_next >= eff_rounds) begin
          round_cnt <= '0;
        end else begin
          round_cnt <= round_next[pas_pkg::ROUND_W-1:0];
        end
      end
      if (state == pas_pkg::ST_CLEAR) begin
        clr_addr <= (clr_addr == ADDR_LAST) ? '0 : clr_addr + 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item_pending <= 1'b1;
      end else if (load_out) begin
        item_pending <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture, result build-up and output payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_op      <= in_op;
      item_window  <= in_window;
      item_channel <= in_channel;
      item_sidx    <= in_sidx;
      item_sample  <= s_axis_tdata[SMP_LO +: pas_pkg::SAMPLE_W];
      item_last    <= s_axis_tlast;
      corr_r       <= '0;
      avg_r        <= 1'b0;
    end else begin
      if (state == pas_pkg::ST_EXEC && item_op == pas_pkg::OP_SUB) begin
        corr_r <= pas_pkg::CORR_W'(item_sample) - pas_pkg::CORR_W'(ped);
      end
      if (state == pas_pkg::ST_ROUND && item_last && (round_next >= eff_rounds)) begin
        avg_r <= 1'b1;
      end
    end
    // Walk index over the window's slots
    if (state == pas_pkg::ST_ROUND) begin
      k <= '0;
    end else if (state == pas_pkg::ST_AV_WAIT && div_done) begin
      k <= k + 1'b1;
    end
    if (load_out) begin
      out_corrected <= corr_r;
      out_averaged  <= avg_r;
      out_round     <= round_cnt;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_round, out_averaged, out_corrected};

endmodule

`default_nettype wire

@@ tb/pedestal_average_and_subtract_top_test.sv @@
// Self-checking testbench for the pedestal average and subtract engine.
// Drives the input stream and the rounds register, predicts every result.
// Depends on pas_pkg and pedestal_average_and_subtract_top.

module pedestal_average_and_subtract_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode with no effect on the store
  localparam pas_pkg::opcode_t OP_NONE = 2'd3;

  localparam int SLOTS_PER_WINDOW = pas_pkg::CHANNELS_DEF * pas_pkg::SAMPLES_DEF;
  localparam int STORE_DEPTH      = pas_pkg::WINDOWS_DEF * SLOTS_PER_WINDOW;

  typedef logic [pas_pkg::WINDOW_W-1:0]  window_t;
  typedef logic [pas_pkg::CHANNEL_W-1:0] channel_t;
  typedef logic [pas_pkg::SIDX_W-1:0]    sidx_t;
  typedef logic [pas_pkg::SAMPLE_W-1:0]  sample_t;
  typedef logic [pas_pkg::DATA_W-1:0]    store_word_t;
  typedef logic [pas_pkg::CORR_W-1:0]    corr_t;
  typedef logic [pas_pkg::ROUND_W-1:0]   round_t;
  typedef logic [pas_pkg::ROUNDS_W-1:0]  rounds_t;

  typedef struct packed {
    pas_pkg::opcode_t op;
    window_t          window;
    channel_t         channel;
    sidx_t            sidx;
    sample_t          sample;
    logic             last;
  } ped_item_t;

  typedef struct packed {
    corr_t  corrected;
    logic   averaged;
    round_t round_now;
  } ped_result_t;

  typedef struct packed {
    ped_item_t   item;
    logic        typed;
    ped_result_t result;
  } dir_row_t;

  localparam ped_result_t NO_RESULT = '0;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  rounds_t                         cfg_wdata = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // opcode, window, channel, sample_index, sample, zero fill
  logic [pas_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // corrected, averaged, round_now, zero fill
  logic [pas_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  pedestal_average_and_subtract_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted copy of the engine state
  store_word_t ped_store [STORE_DEPTH];
  round_t      round_count = '0;
  rounds_t     rounds_value = pas_pkg::ROUNDS_RESET;

  ped_result_t pending_results [$];

  // Shared idling controls and run statistics
  bit no_idle = 1'b0;
  bit gapless = 1'b0;
  int hold_cycles = 0;
  int clears_left = 2;
  int lasts_left = 40;
  int items_sent = 0;
  int results_checked = 0;
  int averagings = 0;
  int clears_seen = 0;
  int mismatches = 0;

  // Directed rows: typed expectations where they are obvious, predictor elsewhere
  dir_row_t directed_rows [17] = '{
    '{'{pas_pkg::OP_SUB, 6'd0, 4'd0, 5'd0, 12'd0, 1'b0}, 1'b1, '{24'd0, 1'b0, 10'd0}},
    '{'{pas_pkg::OP_SUB, 6'd63, 4'd15, 5'd31, 12'd4095, 1'b0}, 1'b1, '{24'd4095, 1'b0, 10'd0}},
    '{'{pas_pkg::OP_ACCUM, 6'd63, 4'd15, 5'd31, 12'd4095, 1'b0}, 1'b1, '{24'd0, 1'b0, 10'd0}},
    '{'{pas_pkg::OP_SUB, 6'd63, 4'd15, 5'd31, 12'd0, 1'b0}, 1'b1, '{24'hFFF001, 1'b0, 10'd0}},
    '{'{pas_pkg::OP_ACCUM, 6'd63, 4'd15, 5'd31, 12'd4095, 1'b0}, 1'b0, NO_RESULT},
    '{'{pas_pkg::OP_ACCUM, 6'd63, 4'd0, 5'd0, 12'd100, 1'b1}, 1'b1, '{24'd0, 1'b1, 10'd0}},
    '{'{pas_pkg::OP_SUB, 6'd63, 4'd15, 5'd31, 12'd4095, 1'b0}, 1'b0, NO_RESULT},
    '{'{OP_NONE, 6'd42, 4'd5, 5'd17, 12'hAAA, 1'b1}, 1'b1, '{24'd0, 1'b0, 10'd0}},
    '{'{pas_pkg::OP_ACCUM, 6'd0, 4'd0, 5'd0, 12'd0, 1'b0}, 1'b0, NO_RESULT},
    '{'{pas_pkg::OP_ACCUM, 6'd0, 4'd0, 5'd0, 12'h555, 1'b1}, 1'b0, NO_RESULT},
    '{'{pas_pkg::OP_CLEAR, 6'd21, 4'd10, 5'd21, 12'h555, 1'b0}, 1'b1, '{24'd0, 1'b0, 10'd0}},
    '{'{pas_pkg::OP_SUB, 6'd63, 4'd15, 5'd31, 12'd0, 1'b0}, 1'b1, '{24'd0, 1'b0, 10'd0}},
    '{'{pas_pkg::OP_ACCUM, 6'd1, 4'd2, 5'd3, 12'd2049, 1'b0}, 1'b0, NO_RESULT},
    '{'{pas_pkg::OP_SUB, 6'd1, 4'd2, 5'd3, 12'd2048, 1'b0}, 1'b0, NO_RESULT},
    '{'{pas_pkg::OP_ACCUM, 6'd2, 4'd5, 5'd7, 12'h800, 1'b1}, 1'b0, NO_RESULT},
    '{'{pas_pkg::OP_SUB, 6'd2, 4'd5, 5'd7, 12'h7FF, 1'b0}, 1'b0, NO_RESULT},
    '{'{pas_pkg::OP_SUB, 6'd0, 4'd0, 5'd0, 12'hFFF, 1'b1}, 1'b0, NO_RESULT}
  };

  // Advance the predicted state by one item and return its result
  function automatic ped_result_t predict_pedestal(input ped_item_t it);
    ped_result_t res;
    int slot;
    int sum;
    int divisor;
    int bumped;
    int base;
    res = '0;
    slot = (int'(it.window) * pas_pkg::CHANNELS_DEF + int'(it.channel)) * pas_pkg::SAMPLES_DEF
           + int'(it.sidx);
    if (rounds_value == '0) begin
      divisor = 1;
    end else if (rounds_value > pas_pkg::ROUNDS_MAX) begin
      divisor = int'(pas_pkg::ROUNDS_MAX);
    end else begin
      divisor = int'(rounds_value);
    end
    case (it.op)
      pas_pkg::OP_CLEAR: begin
        foreach (ped_store[k]) ped_store[k] = '0;
        clears_seen++;
      end
      pas_pkg::OP_ACCUM: begin
        sum = int'(ped_store[slot]) + int'(it.sample);
        ped_store[slot] = (sum > int'(pas_pkg::STORE_MAX)) ? pas_pkg::STORE_MAX
                                                           : store_word_t'(sum);
        if (it.last) begin
          bumped = int'(round_count) + 1;
          if (bumped >= divisor) begin
            // Capture count reached: divide the whole window
            round_count = '0;
            res.averaged = 1'b1;
            averagings++;
            base = int'(it.window) * SLOTS_PER_WINDOW;
            for (int k = 0; k < SLOTS_PER_WINDOW; k++)
              ped_store[base + k] = store_word_t'(int'(ped_store[base + k]) / divisor);
          end else begin
            round_count = round_t'(bumped);
          end
        end
      end
      pas_pkg::OP_SUB: res.corrected = corr_t'(int'(it.sample) - int'(ped_store[slot]));
      default: ;
    endcase
    res.round_now = round_count;
    return res;
  endfunction

  // Draw an item, mostly on a few hot slots so that pedestals build up
  function automatic ped_item_t random_item();
    ped_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (clears_left > 0 && $urandom_range(0, 299) == 0) begin
      it.op = pas_pkg::OP_CLEAR;
      clears_left--;
    end else if (pick < 2) begin
      it.op = OP_NONE;
    end else if (pick < 57) begin
      it.op = pas_pkg::OP_ACCUM;
    end else begin
      it.op = pas_pkg::OP_SUB;
    end
    if ($urandom_range(0, 3) != 0) begin
      it.window  = ($urandom_range(0, 2) == 0) ? 6'd63 : window_t'($urandom_range(0, 1));
      it.channel = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'd15;
      it.sidx    = sidx_t'($urandom_range(0, 3));
    end else begin
      it.window  = window_t'($urandom);
      it.channel = channel_t'($urandom);
      it.sidx    = sidx_t'($urandom);
    end
    pick = $urandom_range(0, 9);
    it.sample = (pick == 0) ? '0 : (pick == 1) ? '1 : sample_t'($urandom);
    // Keep captures rare: each averaging walks a whole window
    if (it.op == pas_pkg::OP_ACCUM) begin
      it.last = 1'b0;
      if (lasts_left > 0 && $urandom_range(0, 31) == 0) begin
        it.last = 1'b1;
        lasts_left--;
      end
    end else begin
      it.last = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // Offer one item after a random gap, predict it once it is transferred
  task automatic send_item(input ped_item_t it, input logic typed, input ped_result_t result);
    int gap;
    ped_result_t predicted;
    if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
    gap = (no_idle || gapless) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.sample, it.sidx, it.channel, it.window, it.op};
    s_axis_tlast  <= it.last;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predicted = predict_pedestal(it);
    pending_results.push_back(typed ? result : predicted);
    items_sent++;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(random_item(), 1'b0, NO_RESULT);
  endtask

  // Write the rounds register once the engine has drained and gone idle
  task automatic write_rounds(input rounds_t value);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    rounds_value = value;
    cfg_we <= 1'b0;
  endtask

  // Stimulus and end of run
  initial begin : drive_items
    ped_item_t it;
    foreach (ped_store[k]) ped_store[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

    // Zero rounds behaves as one
    write_rounds(11'd0);
    run_random(40);

    // Long output stall while input keeps coming
    write_rounds(11'd2);
    run_random(30);
    hold_cycles = 400;
    gapless = 1'b1;
    run_random(16);
    gapless = 1'b0;
    run_random(30);

    // Above the maximum clamps to 1024; walk the round counter through its range
    write_rounds(11'd2047);
    repeat (1030) begin
      it = random_item();
      it.op = pas_pkg::OP_ACCUM;
      it.last = 1'b1;
      send_item(it, 1'b0, NO_RESULT);
    end

    write_rounds(11'd3);
    run_random(40);

    write_rounds(rounds_t'($urandom_range(4, 16)));
    run_random(40);

    write_rounds(pas_pkg::ROUNDS_RESET);
    run_random(30);

    // Drain and let the engine settle
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Sent %0d items, checked %0d results, %0d window averagings, %0d store clears.",
             items_sent, results_checked, averagings, clears_seen);
    $display("Covered rounds of zero, two, three and above the maximum, a full round count.");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, plus the one long hold on request
  initial begin : accept_results
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  // Compare each transferred result with the oldest prediction
  always @(posedge clk) begin : check_results
    ped_result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tdata[pas_pkg::CORR_W-1:0] !== want.corrected) begin
          $error("corrected: expected %0d, got %0d",
                 $signed(want.corrected), $signed(m_axis_tdata[pas_pkg::CORR_W-1:0]));
          mismatches++;
        end
        if (m_axis_tdata[pas_pkg::CORR_W] !== want.averaged) begin
          $error("averaged: expected %0d, got %0d", want.averaged,
                 m_axis_tdata[pas_pkg::CORR_W]);
          mismatches++;
        end
        if (m_axis_tdata[pas_pkg::CORR_W+1 +: pas_pkg::ROUND_W] !== want.round_now) begin
          $error("round_now: expected %0d, got %0d",
                 want.round_now, m_axis_tdata[pas_pkg::CORR_W+1 +: pas_pkg::ROUND_W]);
          mismatches++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
src/pas_pkg.sv
src/pas_store.sv
src/pas_div.sv
src/pedestal_average_and_subtract_top.sv
tb/pedestal_average_and_subtract_top_test.sv
